// ----- hdl/next_fit_zone_allocator_assert.svh -----
// assertion macros used by the allocator top level
`ifndef NEXT_FIT_ZONE_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_ZONE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define NFZA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NFZA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/nfza_pkg.sv -----
// shared constants, command and status types for the next-fit allocator
package nfza_pkg;

	localparam int ARENA_WORDS  = 4096;
	localparam int AW           = 12;
	localparam int WW           = 13;
	localparam int TAG_W        = 4;
	localparam int HEADER_BYTES = 20;
	localparam int HEADER_WORDS = (HEADER_BYTES + 3) / 4;
	localparam int WORD_BYTES   = 4;
	localparam int GUARD_BYTES  = 4;
	localparam int NEED_ADD     = HEADER_WORDS * WORD_BYTES + GUARD_BYTES + WORD_BYTES - 1;
	localparam int MEM_W        = 1 + WW + TAG_W;

	localparam logic [10:0] MIN_FRAG_RESET = 11'd64;

	// opcodes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_TAG   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SPACE = 3'd1;
	localparam logic [2:0] ST_ZERO_TAG = 3'd2;
	localparam logic [2:0] ST_BAD      = 3'd3;
	localparam logic [2:0] ST_FREED    = 3'd4;

	// register indexes
	localparam logic [0:0] REG_MIN_FRAG = 1'd0;

	// datapath actions
	localparam logic [4:0] ACT_NONE   = 5'd0;
	localparam logic [4:0] ACT_LOAD   = 5'd1;
	localparam logic [4:0] ACT_CLR    = 5'd2;
	localparam logic [4:0] ACT_A_RD   = 5'd3;
	localparam logic [4:0] ACT_A_EV   = 5'd4;
	localparam logic [4:0] ACT_A_SPL  = 5'd5;
	localparam logic [4:0] ACT_A_OWN  = 5'd6;
	localparam logic [4:0] ACT_F_RD   = 5'd7;
	localparam logic [4:0] ACT_F_EV   = 5'd8;
	localparam logic [4:0] ACT_R_PRVD = 5'd9;
	localparam logic [4:0] ACT_R_PEV  = 5'd10;
	localparam logic [4:0] ACT_R_NRD  = 5'd11;
	localparam logic [4:0] ACT_R_NEV  = 5'd12;
	localparam logic [4:0] ACT_R_FIN  = 5'd13;
	localparam logic [4:0] ACT_T_RD   = 5'd14;
	localparam logic [4:0] ACT_T_EV   = 5'd15;
	localparam logic [4:0] ACT_OUT    = 5'd16;

	typedef struct packed {
		logic [4:0] act;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       tag_zero;
		logic       addr_low;
		logic       sweep_last;
		logic       fit;
		logic       split;
		logic       back;
		logic       rd_start;
		logic       rd_free;
		logic       own_match;
		logic       entry_zero;
		logic       n_in;
		logic       p_end;
		logic       out_full;
	} sts_t;

endpackage

// ----- hdl/nfza_datapath.sv -----
// block table memories, walk registers and result register
module nfza_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  nfza_pkg::cmd_t      cmd,
	output nfza_pkg::sts_t      sts,
	input  logic [31:0]         in_data,
	input  logic [10:0]         min_frag,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [47:0]         out_data
);

	localparam int AW = nfza_pkg::AW;
	localparam int WW = nfza_pkg::WW;
	localparam int MW = nfza_pkg::MEM_W;

	// header memory {start, words, owner} and previous-block memory
	logic [MW-1:0] mem [nfza_pkg::ARENA_WORDS];
	logic [AW-1:0] prv [nfza_pkg::ARENA_WORDS];

	logic [MW-1:0] rd_q;
	logic [AW-1:0] prv_q;

	logic          mem_re, mem_we, prv_re, prv_we;
	logic [AW-1:0] mem_ra, mem_wa, prv_ra, prv_wa, prv_wd;
	logic [MW-1:0] mem_wd;

	logic [1:0]    op_q;
	logic [WW-1:0] need_q;
	logic [3:0]    tag_q;
	logic [AW-1:0] addr_q;
	logic [WW-1:0] p_q;
	logic [AW-1:0] first_q, b_q, pp_q, f_q, rover_q, cnt_q;
	logic [WW-1:0] wb_q, nx_q, n_q;
	logic          split_q;
	logic [14:0]   used_q;
	logic [12:0]   freed_q;
	logic [2:0]    status_q;
	logic [AW-1:0] payload_q;
	logic          out_v_q;
	logic [47:0]   out_q;

	logic          rd_start;
	logic [WW-1:0] rd_words;
	logic [3:0]    rd_own;
	logic          fit, split, back, rel;
	logic [WW-1:0] diff, p_adv, p_wrap, n_sum;
	logic [14:0]   extra, need_sum;
	logic [AW-1:0] entry_addr, a_free, f_calc;
	logic [MW-1:0] sweep_wd;

	// decode of the registered header read
	assign rd_start = rd_q[MW-1];
	assign rd_words = rd_q[MW-2:4];
	assign rd_own   = rd_q[3:0];

	// fit test, split test and walk step
	assign fit        = (rd_own == 4'd0) && (rd_words >= need_q);
	assign diff       = rd_words - need_q;
	assign extra      = {diff, 2'b00};
	assign split      = extra > {4'd0, min_frag};
	assign p_adv      = p_q + rd_words;
	assign p_wrap     = p_adv[WW-1] ? '0 : p_adv;
	assign back       = p_wrap[AW-1:0] == first_q;
	assign entry_addr = (cmd.act == nfza_pkg::ACT_T_EV) ? p_q[AW-1:0] : b_q;
	assign n_sum      = {1'b0, b_q} + wb_q;
	assign a_free     = addr_q - AW'(nfza_pkg::HEADER_WORDS);
	assign f_calc     = b_q + need_q[AW-1:0];
	assign need_sum   = 15'(in_data[15:2]) + 15'(nfza_pkg::NEED_ADD);
	assign sweep_wd   = (cnt_q == '0) ? {1'b1, WW'(nfza_pkg::ARENA_WORDS), 4'd0} : '0;
	assign rel        = ((cmd.act == nfza_pkg::ACT_F_EV) && rd_start && (rd_own != 4'd0)) ||
	                    ((cmd.act == nfza_pkg::ACT_T_EV) && (rd_own == tag_q));

	// status to controller
	always_comb begin
		sts.op         = op_q;
		sts.tag_zero   = tag_q == 4'd0;
		sts.addr_low   = addr_q < AW'(nfza_pkg::HEADER_WORDS);
		sts.sweep_last = cnt_q == '1;
		sts.fit        = fit;
		sts.split      = split;
		sts.back       = back;
		sts.rd_start   = rd_start;
		sts.rd_free    = rd_own == 4'd0;
		sts.own_match  = rd_own == tag_q;
		sts.entry_zero = entry_addr == '0;
		sts.n_in       = !n_sum[WW-1];
		sts.p_end      = p_q[WW-1];
		sts.out_full   = out_v_q;
	end

	// memory port selection per action
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		prv_re = 1'b0;
		prv_ra = entry_addr;
		prv_we = 1'b0;
		prv_wa = '0;
		prv_wd = b_q;
		case (cmd.act)
			nfza_pkg::ACT_CLR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = sweep_wd;
			end
			nfza_pkg::ACT_A_RD: begin
				mem_re = 1'b1;
				mem_ra = p_q[AW-1:0];
			end
			nfza_pkg::ACT_A_SPL: begin
				mem_we = 1'b1;
				mem_wa = f_calc;
				mem_wd = {1'b1, wb_q - need_q, 4'd0};
				prv_we = 1'b1;
				prv_wa = f_calc;
			end
			nfza_pkg::ACT_A_OWN: begin
				mem_we = 1'b1;
				mem_wa = b_q;
				mem_wd = {1'b1, wb_q, tag_q};
				prv_we = split_q && !nx_q[WW-1];
				prv_wa = nx_q[AW-1:0];
				prv_wd = f_q;
			end
			nfza_pkg::ACT_F_RD: begin
				mem_re = 1'b1;
				mem_ra = a_free;
			end
			nfza_pkg::ACT_F_EV, nfza_pkg::ACT_T_EV: begin
				prv_re = 1'b1;
			end
			nfza_pkg::ACT_R_PRVD: begin
				mem_re = 1'b1;
				mem_ra = prv_q;
			end
			nfza_pkg::ACT_R_PEV: begin
				mem_we = rd_own == 4'd0;
				mem_wa = b_q;
				mem_wd = {1'b0, wb_q, 4'd0};
			end
			nfza_pkg::ACT_R_NRD: begin
				mem_re = !n_sum[WW-1];
				mem_ra = n_sum[AW-1:0];
			end
			nfza_pkg::ACT_R_NEV: begin
				mem_we = rd_own == 4'd0;
				mem_wa = n_q[AW-1:0];
				mem_wd = {1'b0, rd_words, rd_own};
			end
			nfza_pkg::ACT_R_FIN: begin
				mem_we = 1'b1;
				mem_wa = b_q;
				mem_wd = {1'b1, wb_q, 4'd0};
				prv_we = !n_sum[WW-1];
				prv_wa = n_sum[AW-1:0];
			end
			nfza_pkg::ACT_T_RD: begin
				mem_re = !p_q[WW-1];
				mem_ra = p_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (prv_we)
			prv[prv_wa] <= prv_wd;
		if (prv_re)
			prv_q <= prv[prv_ra];
	end

	// rover, usage total, sweep counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rover_q <= '0;
			used_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			case (cmd.act)
				nfza_pkg::ACT_LOAD: cnt_q <= '0;
				nfza_pkg::ACT_CLR: begin
					cnt_q   <= cnt_q + AW'(1);
					rover_q <= '0;
					used_q  <= '0;
				end
				nfza_pkg::ACT_A_OWN: begin
					used_q  <= used_q + {wb_q, 2'b00};
					rover_q <= n_sum[WW-1] ? '0 : n_sum[AW-1:0];
				end
				nfza_pkg::ACT_R_NRD: rover_q <= b_q;
				nfza_pkg::ACT_T_RD: begin
					if (p_q[WW-1])
						rover_q <= '0;
				end
				default: begin
				end
			endcase
			if (rel)
				used_q <= used_q - {rd_words, 2'b00};
			if (cmd.act == nfza_pkg::ACT_OUT)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		case (cmd.act)
			nfza_pkg::ACT_LOAD: begin
				op_q      <= in_data[1:0];
				tag_q     <= in_data[19:16];
				addr_q    <= in_data[31:20];
				need_q    <= need_sum[14:2];
				p_q       <= (in_data[1:0] == nfza_pkg::OP_TAG) ? '0 : {1'b0, rover_q};
				first_q   <= rover_q;
				freed_q   <= '0;
				payload_q <= '0;
				split_q   <= 1'b0;
				if ((in_data[1:0] == nfza_pkg::OP_ALLOC || in_data[1:0] == nfza_pkg::OP_TAG)
				    && in_data[19:16] == 4'd0)
					status_q <= nfza_pkg::ST_ZERO_TAG;
				else if (in_data[1:0] == nfza_pkg::OP_FREE &&
				         in_data[31:20] < AW'(nfza_pkg::HEADER_WORDS))
					status_q <= nfza_pkg::ST_BAD;
				else
					status_q <= nfza_pkg::ST_OK;
			end
			nfza_pkg::ACT_A_EV: begin
				if (fit) begin
					b_q     <= p_q[AW-1:0];
					wb_q    <= rd_words;
					split_q <= split;
				end else begin
					p_q <= p_wrap;
					if (back)
						status_q <= nfza_pkg::ST_NO_SPACE;
				end
			end
			nfza_pkg::ACT_A_SPL: begin
				f_q  <= f_calc;
				nx_q <= n_sum;
				wb_q <= need_q;
			end
			nfza_pkg::ACT_A_OWN: payload_q <= b_q + AW'(nfza_pkg::HEADER_WORDS);
			nfza_pkg::ACT_F_RD: b_q <= a_free;
			nfza_pkg::ACT_F_EV: begin
				if (!rd_start)
					status_q <= nfza_pkg::ST_BAD;
				else if (rd_own == 4'd0)
					status_q <= nfza_pkg::ST_FREED;
			end
			nfza_pkg::ACT_T_EV: begin
				if (rd_own != tag_q)
					p_q <= p_adv;
			end
			nfza_pkg::ACT_R_PRVD: pp_q <= prv_q;
			nfza_pkg::ACT_R_PEV: begin
				if (rd_own == 4'd0) begin
					wb_q <= wb_q + rd_words;
					b_q  <= pp_q;
				end
			end
			nfza_pkg::ACT_R_NRD: n_q <= n_sum;
			nfza_pkg::ACT_R_NEV: begin
				if (rd_own == 4'd0)
					wb_q <= wb_q + rd_words;
			end
			nfza_pkg::ACT_R_FIN: p_q <= n_sum;
			nfza_pkg::ACT_OUT: out_q <= {5'd0, freed_q, used_q, payload_q, status_q};
			default: begin
			end
		endcase
		// release entry: remember block, and count it for free-by-tag
		if (rel) begin
			wb_q <= rd_words;
			b_q  <= entry_addr;
			if (op_q == nfza_pkg::OP_TAG)
				freed_q <= freed_q + 13'd1;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

// ----- hdl/nfza_ctrl.sv -----
// sequencer for allocate, free, free-by-tag and clear
module nfza_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	input  nfza_pkg::sts_t sts,
	output nfza_pkg::cmd_t cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_INIT   = 5'd1;
	localparam logic [4:0] S_DISP   = 5'd2;
	localparam logic [4:0] S_CLR    = 5'd3;
	localparam logic [4:0] S_A_RD   = 5'd4;
	localparam logic [4:0] S_A_EV   = 5'd5;
	localparam logic [4:0] S_A_SPL  = 5'd6;
	localparam logic [4:0] S_A_OWN  = 5'd7;
	localparam logic [4:0] S_F_RD   = 5'd8;
	localparam logic [4:0] S_F_EV   = 5'd9;
	localparam logic [4:0] S_R_PRVD = 5'd10;
	localparam logic [4:0] S_R_PEV  = 5'd11;
	localparam logic [4:0] S_R_NRD  = 5'd12;
	localparam logic [4:0] S_R_NEV  = 5'd13;
	localparam logic [4:0] S_R_FIN  = 5'd14;
	localparam logic [4:0] S_T_RD   = 5'd15;
	localparam logic [4:0] S_T_EV   = 5'd16;
	localparam logic [4:0] S_DONE   = 5'd17;

	logic [4:0] state_q, state_d;

	assign in_ready = state_q == S_IDLE;

	// next state and datapath action
	always_comb begin
		state_d = state_q;
		cmd.act = nfza_pkg::ACT_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = nfza_pkg::ACT_LOAD;
					state_d = S_DISP;
				end
			end
			S_INIT: begin
				cmd.act = nfza_pkg::ACT_CLR;
				if (sts.sweep_last)
					state_d = S_IDLE;
			end
			S_DISP: begin
				case (sts.op)
					nfza_pkg::OP_ALLOC: state_d = sts.tag_zero ? S_DONE : S_A_RD;
					nfza_pkg::OP_FREE:  state_d = sts.addr_low ? S_DONE : S_F_RD;
					nfza_pkg::OP_TAG:   state_d = sts.tag_zero ? S_DONE : S_T_RD;
					default:            state_d = S_CLR;
				endcase
			end
			S_CLR: begin
				cmd.act = nfza_pkg::ACT_CLR;
				if (sts.sweep_last)
					state_d = S_DONE;
			end
			S_A_RD: begin
				cmd.act = nfza_pkg::ACT_A_RD;
				state_d = S_A_EV;
			end
			S_A_EV: begin
				cmd.act = nfza_pkg::ACT_A_EV;
				if (sts.fit)
					state_d = sts.split ? S_A_SPL : S_A_OWN;
				else
					state_d = sts.back ? S_DONE : S_A_RD;
			end
			S_A_SPL: begin
				cmd.act = nfza_pkg::ACT_A_SPL;
				state_d = S_A_OWN;
			end
			S_A_OWN: begin
				cmd.act = nfza_pkg::ACT_A_OWN;
				state_d = S_DONE;
			end
			S_F_RD: begin
				cmd.act = nfza_pkg::ACT_F_RD;
				state_d = S_F_EV;
			end
			S_F_EV: begin
				cmd.act = nfza_pkg::ACT_F_EV;
				if (!sts.rd_start || sts.rd_free)
					state_d = S_DONE;
				else
					state_d = sts.entry_zero ? S_R_NRD : S_R_PRVD;
			end
			S_R_PRVD: begin
				cmd.act = nfza_pkg::ACT_R_PRVD;
				state_d = S_R_PEV;
			end
			S_R_PEV: begin
				cmd.act = nfza_pkg::ACT_R_PEV;
				state_d = S_R_NRD;
			end
			S_R_NRD: begin
				cmd.act = nfza_pkg::ACT_R_NRD;
				state_d = sts.n_in ? S_R_NEV : S_R_FIN;
			end
			S_R_NEV: begin
				cmd.act = nfza_pkg::ACT_R_NEV;
				state_d = S_R_FIN;
			end
			S_R_FIN: begin
				cmd.act = nfza_pkg::ACT_R_FIN;
				state_d = (sts.op == nfza_pkg::OP_FREE) ? S_DONE : S_T_RD;
			end
			S_T_RD: begin
				cmd.act = nfza_pkg::ACT_T_RD;
				state_d = sts.p_end ? S_DONE : S_T_EV;
			end
			S_T_EV: begin
				cmd.act = nfza_pkg::ACT_T_EV;
				if (sts.own_match)
					state_d = sts.entry_zero ? S_R_NRD : S_R_PRVD;
				else
					state_d = S_T_RD;
			end
			S_DONE: begin
				if (!sts.out_full || out_ready) begin
					cmd.act = nfza_pkg::ACT_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/next_fit_zone_allocator.sv -----
// next-fit allocator top level: stream channels, register port, assertions
//
// Input items arrive on s_tvalid/s_tready/s_tdata; each item yields exactly
// one result on m_tvalid/m_tready/m_tdata. One item is in work at a time.
// Allocate walks the blocks from the rover and splits off the remainder when
// it exceeds min_fragment_bytes; free reads the block header below the address
// and releases the block, merging it with free neighbours; free-by-tag walks
// every block from address 0 and releases each one with the tag; clear sweeps
// the header memory; a zero tag or an address below the header goes to the result.
// s_tready returns in the cycle after the result is loaded. Every step is bound
// by the single read port of the header memory, one header access per cycle.
// The result sits in an output register, so a new item may be taken while
// the result still waits; a stalled m_tready only holds the next result in
// its final state. After arst_n the block sweeps the 4096-entry header
// memory, one entry a cycle, with s_tready low; register writes are taken
// at any time. min_fragment_bytes sits at byte address 0 of the register
// port and resets to 64.
`include "next_fit_zone_allocator_assert.svh"

module next_fit_zone_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], alloc_bytes[15:2], block_tag[19:16], block_address[31:20]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], payload_address[14:3], used_bytes[29:15], freed_count[42:30]
	output logic [47:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [10:0]    min_frag_q;
	logic           reg_hit;
	nfza_pkg::cmd_t cmd;
	nfza_pkg::sts_t sts;

	// register port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[1:0] == 2'd0) && (paddr[2] == nfza_pkg::REG_MIN_FRAG);
	assign prdata  = reg_hit ? {21'd0, min_frag_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_frag_q <= nfza_pkg::MIN_FRAG_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			min_frag_q <= pwdata[10:0];
		end
	end

	nfza_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	nfza_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.min_frag  (min_frag_q),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	// checks
	`NFZA_ASSERT_IMP(a_used_range, m_tvalid, m_tdata[29:15] <= 15'd16384, "used bytes over arena")
	`NFZA_ASSERT_IMP(a_status_range, m_tvalid, m_tdata[2:0] <= nfza_pkg::ST_FREED, "bad status")
	`NFZA_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")

endmodule
